// File: design/vts_pkg.sv
// Package for the velocity test sequencer: transaction payload structs,
// configuration and state structs, phase and function codes.
// No dependencies.
package vts_pkg;

   localparam int CNT_W  = 17;
   localparam int REF_W  = 32;
   localparam int FB_W   = 16;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Function codes of an input transaction.
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_STOP  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_AW-1:0] CSR_SQUARE_MODE       = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_SQUARE_AMPLITUDE  = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_STEP_AMPLITUDE    = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_HALF_PERIOD_PAIRS = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_STEP_TICKS        = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_BAND_LOW          = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_BAND_HIGH         = 3'd6;
   localparam logic [CSR_AW-1:0] CSR_TIMEOUT_LIMIT     = 3'd7;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_INIT = 3'd1,
      PH_RUN  = 3'd2,
      PH_STOP = 3'd3,
      PH_DONE = 3'd4
   } vts_phase_type;

   typedef struct packed {
      logic [1:0]             func;
      logic signed [FB_W-1:0] speed_feedback;
   } vts_req_type;

   typedef struct packed {
      logic signed [REF_W-1:0] speed_ref;
      logic                    servo_enable;
      logic                    finished;
      logic [2:0]              phase;
   } vts_rsp_type;

   typedef struct packed {
      logic                    square_mode;
      logic signed [REF_W-1:0] square_amplitude;
      logic signed [REF_W-1:0] step_amplitude;
      logic [15:0]             half_period_pairs;
      logic [15:0]             step_ticks;
      logic signed [FB_W-1:0]  band_low;
      logic signed [FB_W-1:0]  band_high;
      logic [15:0]             timeout_limit;
   } vts_cfg_type;

   typedef struct packed {
      vts_phase_type           phase;
      logic [CNT_W-1:0]        tick_count;
      logic                    polarity;
      logic                    stop_pending;
      logic [CNT_W-1:0]        timeout_count;
      logic                    servo_on;
      logic signed [REF_W-1:0] current_ref;
   } vts_state_type;

endpackage

// File: design/vts_csr.sv
// Configuration register bank of the velocity test sequencer.
// Depends on vts_pkg for the register indexes and the config struct.
module vts_csr import vts_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata,
   output vts_cfg_type       cfg
);

   vts_cfg_type cfg_ff;
   vts_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SQUARE_MODE:       cfg_in.square_mode       = csr_wdata[0];
            CSR_SQUARE_AMPLITUDE:  cfg_in.square_amplitude  = csr_wdata;
            CSR_STEP_AMPLITUDE:    cfg_in.step_amplitude    = csr_wdata;
            CSR_HALF_PERIOD_PAIRS: cfg_in.half_period_pairs = csr_wdata[15:0];
            CSR_STEP_TICKS:        cfg_in.step_ticks        = csr_wdata[15:0];
            CSR_BAND_LOW:          cfg_in.band_low          = csr_wdata[15:0];
            CSR_BAND_HIGH:         cfg_in.band_high         = csr_wdata[15:0];
            CSR_TIMEOUT_LIMIT:     cfg_in.timeout_limit     = csr_wdata[15:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/vts_step.sv
// Per-transaction update of the sequencer state and the result it produces.
// Purely combinational; depends on vts_pkg.
module vts_step import vts_pkg::*; (
   input  vts_cfg_type   cfg,
   input  vts_state_type state_cur,
   input  vts_req_type   req,
   output vts_state_type state_nxt,
   output vts_rsp_type   rsp
);

   logic [CNT_W-1:0] limit;
   logic [CNT_W-1:0] tick_inc;
   logic [CNT_W-1:0] tmo_inc;
   logic             settled;
   logic             finish;

   assign limit = cfg.square_mode ? {cfg.half_period_pairs, 1'b0}
                                  : {1'b0, cfg.step_ticks};
   assign tick_inc = (state_cur.tick_count < CNT_MAX) ? state_cur.tick_count + 1'b1
                                                       : state_cur.tick_count;
   assign settled = (req.speed_feedback > cfg.band_low) &&
                    (req.speed_feedback < cfg.band_high);

   // Next state.
   always_comb begin
      state_nxt = state_cur;
      tmo_inc   = state_cur.timeout_count;
      finish    = 1'b0;
      case (req.func)
         FUNC_START: begin
            state_nxt.current_ref   = '0;
            state_nxt.servo_on      = 1'b1;
            state_nxt.tick_count    = '0;
            state_nxt.timeout_count = '0;
            state_nxt.stop_pending  = 1'b0;
            state_nxt.polarity      = 1'b0;
            state_nxt.phase         = PH_INIT;
         end
         FUNC_STOP: begin
            state_nxt.stop_pending = 1'b1;
         end
         FUNC_TICK: begin
            if (state_cur.phase == PH_INIT || state_cur.phase == PH_RUN ||
                state_cur.phase == PH_STOP) begin
               state_nxt.tick_count = tick_inc;
               if (tick_inc >= limit || state_cur.stop_pending) begin
                  state_nxt.current_ref = '0;
                  state_nxt.phase       = PH_STOP;
               end
               // Init falls straight through into the running phase.
               if (state_nxt.phase == PH_INIT) begin
                  if (!cfg.square_mode) begin
                     state_nxt.current_ref = cfg.step_amplitude;
                  end
                  state_nxt.phase = PH_RUN;
               end
               if (state_nxt.phase == PH_RUN) begin
                  if (cfg.square_mode) begin
                     state_nxt.polarity    = ~state_cur.polarity;
                     state_nxt.current_ref = state_nxt.polarity ? cfg.square_amplitude
                                                                : -cfg.square_amplitude;
                  end
               end else if (state_nxt.phase == PH_STOP) begin
                  state_nxt.current_ref = '0;
                  if (state_cur.timeout_count < CNT_MAX) begin
                     tmo_inc = state_cur.timeout_count + 1'b1;
                  end
                  state_nxt.timeout_count = tmo_inc;
                  if (settled || (tmo_inc > {1'b0, cfg.timeout_limit})) begin
                     state_nxt.servo_on = 1'b0;
                     finish             = 1'b1;
                     state_nxt.phase    = PH_DONE;
                  end
               end
            end
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase
   end

   // Result of the transaction.
   always_comb begin
      rsp.speed_ref    = state_nxt.current_ref;
      rsp.servo_enable = state_nxt.servo_on;
      rsp.finished     = finish;
      rsp.phase        = state_nxt.phase;
   end

endmodule

// File: design/velocity_test_sequencer_core.sv
// Top level of the velocity test sequencer: handshake stages, state registers,
// and instances of vts_csr and vts_step. Depends on vts_pkg.
//
// Velocity test sequencer. Each request transaction is a start, a stop request
// or a tick, and produces exactly one response transaction carrying the speed
// reference, the servo enable, a finished flag and the phase. A start
// clears the counters and enters init; ticks then drive a square wave (plus and
// minus square_amplitude until the tick count reaches twice half_period_pairs) or
// a step (step_amplitude until it reaches step_ticks). After the run, or after a stop
// request, the sequencer holds a zero reference and waits for the feedback to
// settle strictly inside the band or for timeout_limit to be exceeded, then
// drops the servo enable and reports finished. A transaction is registered on
// acceptance, evaluated in one pass of combinational logic while it waits in the
// input stage, and its response is registered; one transaction is accepted in
// every cycle while the response side keeps up, and the state registers are the
// only feedback path. Configuration registers must be written through the csr
// port only while no transaction is in flight; the block does not enforce this.
module velocity_test_sequencer_core import vts_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vts_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vts_rsp_type       rsp_data,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   vts_cfg_type   cfg;

   // Input stage.
   logic          in_valid_ff;
   logic          in_valid_in;
   vts_req_type   in_data_ff;

   // Output stage.
   logic          out_valid_ff;
   logic          out_valid_in;
   vts_rsp_type   out_data_ff;

   // Sequencer state.
   vts_state_type state_ff;
   vts_state_type state_in;
   vts_rsp_type   step_rsp;

   logic          out_free;
   logic          advance;
   logic          req_take;

   vts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vts_step u_step (
      .cfg       (cfg),
      .state_cur (state_ff),
      .req       (in_data_ff),
      .state_nxt (state_in),
      .rsp       (step_rsp)
   );

   // The held transaction moves on whenever the response register is empty
   // or is being emptied in this same cycle.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // A finished response always reports the done phase with the servo off.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.finished) |-> (rsp_data.phase == PH_DONE && !rsp_data.servo_enable))
      else $error("finished response without done phase and servo off");

   // The servo is never left on while the sequencer is idle or done.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_IDLE || state_ff.phase == PH_DONE) |-> !state_ff.servo_on)
      else $error("servo enabled outside an active run");

   // With both stages full and the response stalled, no new request is taken.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request accepted while pipeline is stalled and full");

   // A transaction leaving the input stage always lands in the response register.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("evaluated transaction did not reach the response register");

endmodule

// File: bench/vts_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the velocity test sequencer: mirrors the csr writes, predicts one
// response per accepted request and compares responses in order. Depends on vts_pkg.
module vts_checker import vts_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  vts_req_type       req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  vts_rsp_type       rsp_data,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata,
   output int                mismatches,
   output int                outstanding
);

   vts_cfg_type   settings;
   vts_state_type seq;
   vts_rsp_type   predicted_outputs[$];
   vts_rsp_type   want;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] wanted);
      $display("%0t: mismatch on %0s, got %0h, wanted %0h", $realtime, what, got, wanted);
      mismatches++;
   endtask

   // Advances the sequencer by one request and returns the outputs it commands.
   function automatic vts_rsp_type sequencer_step(input vts_req_type req);
      logic [CNT_W-1:0] run_len;
      vts_rsp_type      outs;
      outs = '0;
      case (req.func)
         FUNC_START: begin
            seq.current_ref   = '0;
            seq.servo_on      = 1'b1;
            seq.tick_count    = '0;
            seq.timeout_count = '0;
            seq.stop_pending  = 1'b0;
            seq.polarity      = 1'b0;
            seq.phase         = PH_INIT;
         end
         FUNC_STOP: seq.stop_pending = 1'b1;
         FUNC_TICK: begin
            if (seq.phase == PH_INIT || seq.phase == PH_RUN || seq.phase == PH_STOP) begin
               run_len = settings.square_mode ? {settings.half_period_pairs, 1'b0}
                                              : {1'b0, settings.step_ticks};
               if (seq.tick_count != CNT_MAX) seq.tick_count = seq.tick_count + 1'b1;
               if (seq.tick_count >= run_len || seq.stop_pending) begin
                  seq.current_ref = '0;
                  seq.phase       = PH_STOP;
               end
               if (seq.phase == PH_INIT) begin
                  if (!settings.square_mode) seq.current_ref = settings.step_amplitude;
                  seq.phase = PH_RUN;
               end
               if (seq.phase == PH_RUN) begin
                  if (settings.square_mode) begin
                     seq.polarity    = ~seq.polarity;
                     seq.current_ref = seq.polarity ? settings.square_amplitude
                                                    : 32'sd0 - settings.square_amplitude;
                  end
               end else if (seq.phase == PH_STOP) begin
                  seq.current_ref = '0;
                  if (seq.timeout_count != CNT_MAX)
                     seq.timeout_count = seq.timeout_count + 1'b1;
                  if (($signed(req.speed_feedback) > $signed(settings.band_low) &&
                       $signed(req.speed_feedback) < $signed(settings.band_high)) ||
                      seq.timeout_count > {1'b0, settings.timeout_limit}) begin
                     seq.servo_on  = 1'b0;
                     outs.finished = 1'b1;
                     seq.phase     = PH_DONE;
                  end
               end
            end
         end
         default: ;
      endcase
      outs.speed_ref    = seq.current_ref;
      outs.servo_enable = seq.servo_on;
      outs.phase        = seq.phase;
      return outs;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         settings = '0;
         seq      = '0;
         predicted_outputs.delete();
         outstanding <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SQUARE_MODE:       settings.square_mode       = csr_wdata[0];
               CSR_SQUARE_AMPLITUDE:  settings.square_amplitude  = csr_wdata;
               CSR_STEP_AMPLITUDE:    settings.step_amplitude    = csr_wdata;
               CSR_HALF_PERIOD_PAIRS: settings.half_period_pairs = csr_wdata[15:0];
               CSR_STEP_TICKS:        settings.step_ticks        = csr_wdata[15:0];
               CSR_BAND_LOW:          settings.band_low          = csr_wdata[15:0];
               CSR_BAND_HIGH:         settings.band_high         = csr_wdata[15:0];
               CSR_TIMEOUT_LIMIT:     settings.timeout_limit     = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_outputs.size() == 0) begin
               report_mismatch("unexpected response", rsp_data.speed_ref, '0);
            end else begin
               want = predicted_outputs.pop_front();
               if (rsp_data.speed_ref !== want.speed_ref)
                  report_mismatch("speed_ref", rsp_data.speed_ref, want.speed_ref);
               if (rsp_data.servo_enable !== want.servo_enable)
                  report_mismatch("servo_enable", rsp_data.servo_enable, want.servo_enable);
               if (rsp_data.finished !== want.finished)
                  report_mismatch("finished", rsp_data.finished, want.finished);
               if (rsp_data.phase !== want.phase)
                  report_mismatch("phase", rsp_data.phase, want.phase);
            end
         end
         if (req_valid && req_ready) predicted_outputs.push_back(sequencer_step(req_data));
         outstanding <= predicted_outputs.size();
      end
   end

endmodule

// File: bench/tb_velocity_test_sequencer_core.sv
`timescale 1ns / 100ps
// Testbench top for velocity_test_sequencer_core: clock, reset, request and csr
// stimulus, response back-pressure and the verdict. Depends on vts_pkg and vts_checker.
module tb_velocity_test_sequencer_core;
   import vts_pkg::*;

   // The run is ended when no transaction moves on either channel for this long.
   // The longest legitimate quiet stretch is the deliberate response hold-off.
   localparam int STALL_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 300;
   localparam int BATCH_ITEMS  = 60;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   vts_req_type       req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   vts_rsp_type       rsp_data;
   logic              csr_we    = 1'b0;
   logic [CSR_AW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   int mismatches;
   int outstanding;
   int quiet_cycles = 0;
   int items_sent   = 0;

   // Traffic shaping knobs, set per phase by the stimulus process; hold_done is set by the response side.
   bit sender_idles    = 1'b0;
   bit receiver_stalls = 1'b0;
   bit hold_go         = 1'b0;
   bit hold_done       = 1'b0;

   always #5 clock = ~clock;

   velocity_test_sequencer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   vts_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Response side. Normally ready is either always high or randomly low 82 percent
   // of the time. Once, on request, it holds ready low for a long stretch
   // while the sender keeps offering transactions, so the pipeline backs up and
   // the request channel has to stall.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (receiver_stalls) begin
            rsp_ready <= ($urandom_range(0, 99) >= 82);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: counts cycles in which no transaction is accepted on either channel.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one request transaction and returns at the edge where it is accepted.
   // Valid stays high afterward; back-to-back transactions drop it only when the sender idles.
   task automatic send_item(input logic [1:0] func, input logic [FB_W-1:0] feedback);
      vts_req_type item;
      item.func           = func;
      item.speed_feedback = feedback;
      while (sender_idles && $urandom_range(0, 99) < 82) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (func != 2'd3) items_sent++;
   endtask

   // Stops offering, waits until every predicted response has been consumed, and
   // then pads the wait to cover the input and output stages.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 || rsp_valid) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_AW-1:0] index, input logic [CSR_DW-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Writes every register. Unused upper bits of the narrow registers carry
   // random junk, which the block must ignore.
   task automatic program_settings(input vts_cfg_type c);
      write_reg(CSR_SQUARE_MODE,       {$urandom_range(0, 1) == 1 ? 31'h7FFF_FFFF : 31'h0,
                                        c.square_mode});
      write_reg(CSR_SQUARE_AMPLITUDE,  c.square_amplitude);
      write_reg(CSR_STEP_AMPLITUDE,    c.step_amplitude);
      write_reg(CSR_HALF_PERIOD_PAIRS, {16'($urandom), c.half_period_pairs});
      write_reg(CSR_STEP_TICKS,        {16'($urandom), c.step_ticks});
      write_reg(CSR_BAND_LOW,          {16'($urandom), c.band_low});
      write_reg(CSR_BAND_HIGH,         {16'($urandom), c.band_high});
      write_reg(CSR_TIMEOUT_LIMIT,     {16'($urandom), c.timeout_limit});
      csr_we <= 1'b0;
   endtask

   function automatic logic [REF_W-1:0] pick_amplitude();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h8000_0001;
         3:       return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   // Random settings keep run lengths and timeouts short most of the time, so
   // sequences get through running, stopping and done; the maxima show up rarely.
   function automatic vts_cfg_type random_settings();
      vts_cfg_type c;
      c.square_mode       = 1'($urandom_range(0, 1));
      c.square_amplitude  = pick_amplitude();
      c.step_amplitude    = pick_amplitude();
      c.half_period_pairs = ($urandom_range(0, 99) < 5) ? 16'hFFFF : 16'($urandom_range(0, 10));
      c.step_ticks        = ($urandom_range(0, 99) < 5) ? 16'hFFFF : 16'($urandom_range(0, 20));
      if ($urandom_range(0, 99) < 15) begin
         // Fully random bounds, often an empty band.
         c.band_low  = 16'($urandom);
         c.band_high = 16'($urandom);
      end else begin
         c.band_low  = ($urandom_range(0, 99) < 10) ? 16'sh8000
                                                     : -16'($urandom_range(0, 3000));
         c.band_high = ($urandom_range(0, 99) < 10) ? 16'sh7FFF
                                                     : 16'($urandom_range(0, 3000));
      end
      c.timeout_limit = ($urandom_range(0, 99) < 5) ? 16'hFFFF : 16'($urandom_range(0, 10));
      return c;
   endfunction

   // Feedback is mostly a random 16-bit value; now and then it is placed
   // strictly inside the band so that the settle path is taken.
   function automatic logic [FB_W-1:0] pick_feedback(input vts_cfg_type c);
      int lo;
      int span;
      lo   = c.band_low;
      span = int'(c.band_high) - lo - 1;
      if (span >= 1 && $urandom_range(0, 99) < 12) return 16'(lo + 1 + $urandom_range(0, span - 1));
      return 16'($urandom);
   endfunction

   // One test run: a start followed by ticks, sometimes with a stop request in
   // the middle. A few runs omit the start, and stray transactions are mixed in.
   task automatic run_sequence(input vts_cfg_type c);
      int n_ticks;
      int stop_at;
      n_ticks = $urandom_range(1, 40);
      stop_at = ($urandom_range(0, 99) < 15) ? $urandom_range(0, n_ticks) : -1;
      if ($urandom_range(0, 99) >= 10) send_item(FUNC_START, 16'($urandom));
      for (int i = 0; i < n_ticks; i++) begin
         if (i == stop_at) send_item(FUNC_STOP, 16'($urandom));
         if ($urandom_range(0, 99) < 4) send_item(2'($urandom_range(0, 3)), 16'($urandom));
         send_item(FUNC_TICK, pick_feedback(c));
      end
   endtask

   initial begin
      vts_cfg_type settings;
      int          phase_end;
      int          batch_end;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Square wave at the most negative amplitude, half_period_pairs
      // of two, a narrow band and a short timeout.
      settings.square_mode       = 1'b1;
      settings.square_amplitude  = 32'h8000_0000;
      settings.step_amplitude    = 32'h7FFF_FFFF;
      settings.half_period_pairs = 16'd2;
      settings.step_ticks        = 16'd3;
      settings.band_low          = -16'sd10;
      settings.band_high         = 16'sd10;
      settings.timeout_limit     = 16'd2;
      program_settings(settings);
      send_item(FUNC_TICK, 16'h0000);   // tick while idle is ignored
      send_item(2'd3, 16'hFFFF);        // unused function code is ignored
      send_item(FUNC_START, 16'h0000);
      repeat (4) send_item(FUNC_TICK, 16'h7FFF);
      send_item(FUNC_TICK, 16'h8000);   // still stopping, feedback out of band
      send_item(FUNC_TICK, 16'h0005);   // settles inside the band
      send_item(FUNC_TICK, 16'h0000);   // tick while done is ignored
      send_item(FUNC_STOP, 16'h0000);   // stop request while done
      send_item(FUNC_START, 16'h0000);  // start clears the pending stop
      send_item(FUNC_TICK, 16'h0000);
      send_item(FUNC_STOP, 16'h0000);
      send_item(FUNC_TICK, 16'h0000);   // stop pending: stopping and settled at once
      drain();

      // Step mode with a zero run length, the widest band and no timeout slack.
      settings.square_mode   = 1'b0;
      settings.step_ticks    = 16'd0;
      settings.band_low      = 16'sh8000;
      settings.band_high     = 16'sh7FFF;
      settings.timeout_limit = 16'd0;
      program_settings(settings);
      send_item(FUNC_START, 16'h0000);
      send_item(FUNC_TICK, 16'h8000);   // not above the lower bound, times out
      drain();
      settings.step_ticks    = 16'd2;
      settings.timeout_limit = 16'd1;
      program_settings(settings);
      send_item(FUNC_START, 16'h0000);
      send_item(FUNC_TICK, 16'h7FFF);   // drives the step amplitude
      send_item(FUNC_TICK, 16'h0064);   // step over, settles
      drain();

      // Random part in four traffic phases: no idling, sender idling, receiver
      // stalling, and both. Settings change between batches once drained.
      for (int mode = 0; mode < 4; mode++) begin
         sender_idles    = (mode == 1 || mode == 3);
         receiver_stalls = (mode == 2 || mode == 3);
         phase_end       = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            drain();
            settings = random_settings();
            program_settings(settings);
            // The long response hold-off happens once, with the sender at full rate.
            if (mode == 0) hold_go = 1'b1;
            batch_end = items_sent + BATCH_ITEMS;
            while (items_sent < batch_end && items_sent < phase_end) run_sequence(settings);
         end
      end
      drain();

      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
